@@ sv/utw_pkg.sv @@
// ---------------------------------------------------------------------------
// utw_pkg
// types, constants and the special code point table of the transcoder
// ---------------------------------------------------------------------------
package utw_pkg;

    localparam int CP_W   = 21;
    localparam int SPEC_N = 32;

    localparam logic [7:0] QMARK_BYTE = 8'h3F;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] DASH_BYTE  = 8'h2D;

    localparam logic [CP_W-1:0] CP_TAB      = 21'h00009;
    localparam logic [CP_W-1:0] CP_LF       = 21'h0000A;
    localparam logic [CP_W-1:0] CP_CR       = 21'h0000D;
    localparam logic [CP_W-1:0] CP_HYPHEN   = 21'h02010;
    localparam logic [CP_W-1:0] CP_NB_HYPHEN = 21'h02011;

    // code points behind bytes 0x80..0x9F, zero marks an undefined slot
    localparam logic [15:0] SPECIAL_MAP [SPEC_N] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } utf_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_substitute;
        logic       last_for_input;
        logic       text_done;
    } ansi_beat_t;

    typedef struct packed {
        logic [7:0] code;
        logic       sub;
    } map_res_t;

    typedef struct packed {
        logic [1:0]      n;
        ansi_beat_t      res0;
        ansi_beat_t      res1;
        logic [CP_W-1:0] pc_next;
        logic [1:0]      bp_next;
    } dec_res_t;

endpackage

@@ sv/utw_map.sv @@
// ---------------------------------------------------------------------------
// utw_map
// maps one code point to a windows-1252 byte or a flagged '?'
// ---------------------------------------------------------------------------
module utw_map
    import utw_pkg::*;
(
    input  logic [CP_W-1:0] cp,
    output map_res_t        res
);

    logic       hit;
    logic [4:0] hit_idx;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = 0; k < SPEC_N; k++)
        begin
            if (SPECIAL_MAP[k] != 16'h0000 && cp == {5'd0, SPECIAL_MAP[k]})
            begin
                hit     = 1'b1;
                hit_idx = 5'(k);
            end
        end
    end

    always_comb
    begin
        res.sub  = 1'b0;
        res.code = cp[7:0];
        if (cp == CP_TAB || cp == CP_LF || cp == CP_CR)
        begin
            res.code = SPACE_BYTE;
        end
        else if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF))
        begin
            res.code = cp[7:0];
        end
        else if (hit)
        begin
            res.code = {3'b100, hit_idx};
        end
        else if (cp == CP_HYPHEN || cp == CP_NB_HYPHEN)
        begin
            res.code = DASH_BYTE;
        end
        else
        begin
            res.code = QMARK_BYTE;
            res.sub  = 1'b1;
        end
    end

endmodule

@@ sv/utw_decode.sv @@
// ---------------------------------------------------------------------------
// utw_decode
// one utf-8 byte against the sequence state: results and next state
// ---------------------------------------------------------------------------
module utw_decode
    import utw_pkg::*;
(
    input  utf_beat_t       beat,
    input  logic [CP_W-1:0] pc,
    input  logic [1:0]      bp,
    output dec_res_t        dec
);

    logic [7:0]      b;
    logic            cont;
    logic            pend;
    logic            use_acc;
    logic [CP_W-1:0] acc;
    logic [CP_W-1:0] cp;
    map_res_t        mres;
    logic            ascii;
    logic            lead2;
    logic            lead3;
    logic            lead4;

    assign b       = beat.in_byte;
    assign cont    = (b[7:6] == 2'b10);
    assign pend    = (bp != 2'd0);
    assign use_acc = pend && cont;
    assign acc     = {pc[CP_W-7:0], b[5:0]};
    assign cp      = use_acc ? acc : {13'd0, b};
    assign ascii   = (b[7] == 1'b0);
    assign lead2   = (b[7:5] == 3'b110);
    assign lead3   = (b[7:4] == 4'b1110);
    assign lead4   = (b[7:3] == 5'b11110);

    utw_map u_map (
        .cp  (cp),
        .res (mres)
    );

    always_comb
    begin
        ansi_beat_t r;
        logic [1:0] bp_dec;
        logic       have;

        r        = '0;
        bp_dec   = bp - 2'd1;
        have     = 1'b0;
        dec      = '0;
        dec.pc_next = pc;
        dec.bp_next = bp;

        if (use_acc)
        begin
            dec.bp_next = bp_dec;
            if (bp_dec == 2'd0)
            begin
                dec.res0.out_byte      = mres.code;
                dec.res0.is_substitute = mres.sub;
                dec.n                  = 2'd1;
                dec.pc_next            = '0;
            end
            else
            begin
                dec.pc_next = acc;
            end
        end
        else
        begin
            // broken sequence: flag it, then treat the byte as a fresh lead
            if (pend)
            begin
                dec.res0.out_byte      = QMARK_BYTE;
                dec.res0.is_substitute = 1'b1;
                dec.n                  = 2'd1;
                dec.pc_next            = '0;
                dec.bp_next            = 2'd0;
            end
            if (lead2)
            begin
                dec.pc_next = {16'd0, b[4:0]};
                dec.bp_next = 2'd1;
            end
            else if (lead3)
            begin
                dec.pc_next = {17'd0, b[3:0]};
                dec.bp_next = 2'd2;
            end
            else if (lead4)
            begin
                dec.pc_next = {18'd0, b[2:0]};
                dec.bp_next = 2'd3;
            end
            else
            begin
                have = 1'b1;
                if (ascii)
                begin
                    r.out_byte      = mres.code;
                    r.is_substitute = mres.sub;
                end
                else
                begin
                    r.out_byte      = QMARK_BYTE;
                    r.is_substitute = 1'b1;
                end
            end
        end

        // sequence still open at end of text
        if (beat.end_of_text)
        begin
            if (dec.bp_next != 2'd0)
            begin
                have            = 1'b1;
                r.out_byte      = QMARK_BYTE;
                r.is_substitute = 1'b1;
            end
            dec.pc_next = '0;
            dec.bp_next = 2'd0;
        end

        if (have)
        begin
            if (dec.n == 2'd0)
            begin
                dec.res0 = r;
            end
            else
            begin
                dec.res1 = r;
            end
            dec.n = dec.n + 2'd1;
        end

        if (dec.n == 2'd1)
        begin
            dec.res0.last_for_input = 1'b1;
            dec.res0.text_done      = beat.end_of_text;
        end
        else if (dec.n == 2'd2)
        begin
            dec.res1.last_for_input = 1'b1;
            dec.res1.text_done      = beat.end_of_text;
        end
    end

endmodule

@@ sv/utw_res_fifo.sv @@
// ---------------------------------------------------------------------------
// utw_res_fifo
// four-entry result queue, takes up to two beats a cycle, gives one while ansi_ready is high
// ---------------------------------------------------------------------------
module utw_res_fifo
    import utw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  ansi_beat_t push0,
    input  ansi_beat_t push1,
    output logic       room,
    output logic [2:0] level,
    output logic       ansi_valid,
    input  logic       ansi_ready,
    output ansi_beat_t ansi_data
);

    ansi_beat_t mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       pop;

    assign pop        = ansi_valid && ansi_ready;
    assign ansi_valid = (count_reg != 3'd0);
    assign ansi_data  = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= 3'd2);
    assign level      = count_reg;

    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_n} - {2'd0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

endmodule

@@ sv/utf8_to_winansi_transcoder.sv @@
// path: a taken beat is registered in the input stage, then its results go to the result queue
// throughput: one utf-8 byte per cycle while the result queue has room; a byte with
//   two results gives them one at a time, set by the single-beat output of the result queue
// reset: rst_n clears the input stage, the sequence state and the queue
// ---------------------------------------------------------------------------
// utf8_to_winansi_transcoder
// utf-8 byte stream to windows-1252 bytes, '?' for anything unmappable
// ---------------------------------------------------------------------------
module utf8_to_winansi_transcoder
    import utw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       utf_valid,
    output logic       utf_ready,
    input  utf_beat_t  utf_data,
    output logic       ansi_valid,
    input  logic       ansi_ready,
    output ansi_beat_t ansi_data
);

    // input stage
    logic            in_vld_reg;
    utf_beat_t       in_reg;
    // sequence state: gathered code point bits and missing continuations
    logic [CP_W-1:0] pc_reg;
    logic [1:0]      bp_reg;

    dec_res_t        dec;
    logic            room;
    logic [2:0]      level;
    logic            fire;
    logic [1:0]      push_n;

    // the staged beat moves on once the queue can hold both of its results
    assign fire      = in_vld_reg && room;
    assign utf_ready = !in_vld_reg || fire;
    assign push_n    = fire ? dec.n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pc_reg     <= '0;
            bp_reg     <= '0;
        end
        else
        begin
            if (utf_ready)
            begin
                in_vld_reg <= utf_valid;
            end
            if (fire)
            begin
                pc_reg <= dec.pc_next;
                bp_reg <= dec.bp_next;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (utf_ready && utf_valid)
        begin
            in_reg <= utf_data;
        end
    end

    // decode and map for the staged beat
    utw_decode u_decode (
        .beat (in_reg),
        .pc   (pc_reg),
        .bp   (bp_reg),
        .dec  (dec)
    );

    // result queue, also the output register
    utw_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push0      (dec.res0),
        .push1      (dec.res1),
        .room       (room),
        .level      (level),
        .ansi_valid (ansi_valid),
        .ansi_ready (ansi_ready),
        .ansi_data  (ansi_data)
    );

`ifndef SYNTH
    // queue never runs past its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'd4)
        else $error("result queue overflow");

    // end of text leaves the sequence state clear
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.end_of_text |=> bp_reg == 2'd0 && pc_reg == '0)
        else $error("state not cleared after end of text");

    // end of text always yields a result
    a_eot_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_reg.end_of_text |-> dec.n != 2'd0)
        else $error("end of text gave no result");

    // a beat leaving with results makes the queue non-empty
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |=> ansi_valid)
        else $error("pushed result not visible");
`endif

endmodule

@@ tb/utf8_to_winansi_transcoder_tb.sv @@
// ---------------------------------------------------------------------------
// utf8_to_winansi_transcoder_tb
// drives utf-8 text into the transcoder one byte per beat and checks every
// windows-1252 beat against a local decoder model: directed control codes,
// mapped and unmappable characters, broken and truncated sequences, then
// random text and noise with idling on both sides, then a back-to-back tail
// ---------------------------------------------------------------------------
module utf8_to_winansi_transcoder_tb
    import utw_pkg::*;
();

    // code points behind windows-1252 bytes 0x80..0x9f, zero where undefined
    localparam logic [15:0] CP1252_HIGH [32] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
    };

    // flagged '?' with no end markers, the end markers are added per byte
    localparam ansi_beat_t SUBST_BEAT = {QMARK_BYTE, 3'b100};

    // clock, reset and block inputs, all known from time zero
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       utf_valid  = 1'b0;
    logic       utf_ready;
    utf_beat_t  utf_data   = '0;
    logic       ansi_valid;
    logic       ansi_ready = 1'b0;
    ansi_beat_t ansi_data;

    // decoder model state: code point so far and continuation bytes missing
    logic [CP_W-1:0] cp_acc    = '0;
    logic [1:0]      cont_left = '0;

    // windows-1252 beats the transcoder still owes, oldest first
    ansi_beat_t winansi_q [$];

    // idling controls, switched off for the last part of the run
    logic sender_idle_en    = 1'b1;
    logic receiver_stall_en = 1'b1;
    int   stall_left        = 0;

    // run statistics and failure count
    int fail_cnt    = 0;
    int beats_sent  = 0;
    int beats_seen  = 0;
    int subst_seen  = 0;
    int texts_seen  = 0;

    utf8_to_winansi_transcoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf_valid  (utf_valid),
        .utf_ready  (utf_ready),
        .utf_data   (utf_data),
        .ansi_valid (ansi_valid),
        .ansi_ready (ansi_ready),
        .ansi_data  (ansi_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------

    // windows-1252 byte for one complete code point, '?' flagged if none
    function automatic ansi_beat_t winansi_of(input logic [CP_W-1:0] cp);
        ansi_beat_t r;
        r = SUBST_BEAT;
        if (cp == CP_TAB || cp == CP_LF || cp == CP_CR)
        begin
            r.out_byte      = SPACE_BYTE;
            r.is_substitute = 1'b0;
        end
        else if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF))
        begin
            // ascii and latin-1 pass straight through, nul included
            r.out_byte      = cp[7:0];
            r.is_substitute = 1'b0;
        end
        else if (cp == CP_HYPHEN || cp == CP_NB_HYPHEN)
        begin
            r.out_byte      = DASH_BYTE;
            r.is_substitute = 1'b0;
        end
        else
        begin
            // c1 range itself never matches here, table entries are all above it
            for (int k = 0; k < 32; k++)
            begin
                if (CP1252_HIGH[k] != 16'h0000 && {5'd0, CP1252_HIGH[k]} == cp)
                begin
                    r.out_byte      = 8'h80 | 8'(k);
                    r.is_substitute = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // advance the model by one accepted byte and queue the beats it causes
    task automatic transcode_utf_byte(input utf_beat_t beat);
        ansi_beat_t outs [$];
        ansi_beat_t tail;
        logic [7:0] b;
        b = beat.in_byte;
        if (cont_left != 2'd0 && b[7:6] == 2'b10)
        begin
            // continuation: shift in six bits, masked to the code point width
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                outs   = {outs, winansi_of(cp_acc)};
                cp_acc = '0;
            end
        end
        else
        begin
            // broken sequence: flag it, drop it, then treat the byte as a lead
            if (cont_left != 2'd0)
            begin
                outs      = {outs, SUBST_BEAT};
                cont_left = 2'd0;
                cp_acc    = '0;
            end
            if (!b[7])
                outs = {outs, winansi_of({13'd0, b})};
            else if (b[7:5] == 3'b110)
            begin
                cp_acc    = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_acc    = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_acc    = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
            else
                outs = {outs, SUBST_BEAT};   // stray continuation or f8..ff
        end
        if (beat.end_of_text)
        begin
            // a sequence left open at the end of the text is flagged
            if (cont_left != 2'd0)
                outs = {outs, SUBST_BEAT};
            cont_left = 2'd0;
            cp_acc    = '0;
        end
        if (outs.size() != 0)
        begin
            tail                = outs.pop_back();
            tail.last_for_input = 1'b1;
            tail.text_done      = beat.end_of_text;
            outs                = {outs, tail};
        end
        foreach (outs[i])
            winansi_q = {winansi_q, outs[i]};
    endtask

    // ------------------------------------------------------------------
    // utf-8 side
    // ------------------------------------------------------------------

    // offer one byte, hold it until taken, then update the model
    task automatic send_beat(input logic [7:0] b, input logic eot);
        utf_beat_t beat;
        int        gap;
        beat.in_byte     = b;
        beat.end_of_text = eot;
        if (sender_idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            utf_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // valid is left high after the handshake so the next byte follows
        // without a second assignment in the same step
        utf_valid <= 1'b1;
        utf_data  <= beat;
        @(posedge clk);
        while (!utf_ready)
            @(posedge clk);
        transcode_utf_byte(beat);
        beats_sent++;
    endtask

    // one byte of random text, with an occasional end of text anywhere
    task automatic send_text_byte(input logic [7:0] b);
        send_beat(b, $urandom_range(0, 29) == 0);
    endtask

    // code point drawn from the interesting classes of the mapping
    function automatic logic [CP_W-1:0] draw_code_point();
        int idx;
        case ($urandom_range(0, 7))
            0: return CP_W'($urandom_range(0, 8'h7F));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return CP_TAB;
                    1: return CP_LF;
                    2: return CP_CR;
                    default: return CP_W'(QMARK_BYTE);
                endcase
            end
            2: return CP_W'($urandom_range(8'hA0, 8'hFF));
            3:
            begin
                do
                    idx = $urandom_range(0, 31);
                while (CP1252_HIGH[idx] == 16'h0000);
                return {5'd0, CP1252_HIGH[idx]};
            end
            4: return CP_W'($urandom_range(16'h200F, 16'h2012));
            5: return CP_W'($urandom_range(8'h80, 8'h9F));
            6: return CP_W'($urandom_range(0, 16'hFFFF));
            default: return CP_W'($urandom_range(0, 21'h1FFFFF));
        endcase
    endfunction

    // encode a code point in the shortest form, or one byte longer when overlong
    // is set and that form is under four bytes; with truncate set only a prefix of the sequence goes out
    task automatic send_code_point(input logic [CP_W-1:0] cp, input logic overlong,
                                   input logic truncate);
        logic [7:0] enc [4];
        int         len;
        int         cut;
        if (cp < 21'h80)
            len = 1;
        else if (cp < 21'h800)
            len = 2;
        else if (cp < 21'h10000)
            len = 3;
        else
            len = 4;
        if (overlong && len < 4)
            len++;
        case (len)
            1: enc[0] = {1'b0, cp[6:0]};
            2: enc[0] = {3'b110, cp[10:6]};
            3: enc[0] = {4'b1110, cp[15:12]};
            default: enc[0] = {5'b11110, cp[20:18]};
        endcase
        for (int i = 1; i < len; i++)
            enc[i] = {2'b10, cp[6*(len-1-i) +: 6]};
        cut = (truncate && len > 1) ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < cut; i++)
            send_text_byte(enc[i]);
    endtask

    // stop sending until the transcoder has delivered everything it owes
    task automatic drain_results();
        utf_valid <= 1'b0;
        @(posedge clk);
        while (winansi_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // windows-1252 side: random stalls and checking of every beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ansi_beat_t want;
        if (rst_n && ansi_valid && ansi_ready)
        begin
            if (winansi_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %02h sub %b",
                         $time, ansi_data.out_byte, ansi_data.is_substitute);
                fail_cnt++;
            end
            else
            begin
                want = winansi_q.pop_front();
                if (ansi_data.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %02h, actual %02h",
                             $time, want.out_byte, ansi_data.out_byte);
                    fail_cnt++;
                end
                if (ansi_data.is_substitute !== want.is_substitute)
                begin
                    $display("%0t: is_substitute expected %b, actual %b",
                             $time, want.is_substitute, ansi_data.is_substitute);
                    fail_cnt++;
                end
                if (ansi_data.last_for_input !== want.last_for_input)
                begin
                    $display("%0t: last_for_input expected %b, actual %b",
                             $time, want.last_for_input, ansi_data.last_for_input);
                    fail_cnt++;
                end
                if (ansi_data.text_done !== want.text_done)
                begin
                    $display("%0t: text_done expected %b, actual %b",
                             $time, want.text_done, ansi_data.text_done);
                    fail_cnt++;
                end
                beats_seen++;
                if (want.is_substitute)
                    subst_seen++;
                if (want.text_done)
                    texts_seen++;
            end
        end
        // ready drops now and then for a burst of random length
        if (stall_left > 0)
        begin
            stall_left--;
            ansi_ready <= 1'b0;
        end
        else if (receiver_stall_en && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 18);
            ansi_ready <= 1'b0;
        end
        else
            ansi_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // nul, tab, cr, a literal '?' and del, closing the text on the last
    task automatic test_ascii_and_controls();
        send_beat(8'h00, 1'b0);
        send_beat(8'h09, 1'b0);
        send_beat(8'h0D, 1'b0);
        send_beat(8'h3F, 1'b0);
        send_beat(8'h7F, 1'b1);
    endtask

    // latin-1 top, euro sign, non-breaking hyphen and an unmappable emoji
    task automatic test_multibyte_mapping();
        send_beat(8'hC3, 1'b0);
        send_beat(8'hBF, 1'b0);
        send_beat(8'hE2, 1'b0);
        send_beat(8'h82, 1'b0);
        send_beat(8'hAC, 1'b0);
        send_beat(8'hE2, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h91, 1'b0);
        send_beat(8'hF0, 1'b0);
        send_beat(8'h9F, 1'b0);
        send_beat(8'h98, 1'b0);
        send_beat(8'h80, 1'b1);
    endtask

    // stray continuation, invalid lead, broken sequence re-read as ascii,
    // overlong nul, and a sequence cut short by the end of the text
    task automatic test_broken_and_truncated();
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hC3, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(8'hC0, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hE2, 1'b0);
        send_beat(8'h82, 1'b1);
    endtask

    // mostly well-formed text with random content, some overlong forms,
    // some cut-off sequences and a little noise
    task automatic test_random_text(input int n);
        int stop_at;
        int pick;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                send_text_byte(8'($urandom_range(0, 255)));
            else
                send_code_point(draw_code_point(), $urandom_range(0, 7) == 0, pick == 1);
        end
        send_beat(8'h2E, 1'b1);
    endtask

    // raw random bytes with well-formed characters mixed in
    task automatic test_noise_bytes(input int n);
        int stop_at;
        stop_at = beats_sent + n;
        while (beats_sent < stop_at)
        begin
            if ($urandom_range(0, 3) != 0)
                send_text_byte(8'($urandom_range(0, 255)));
            else
                send_code_point(draw_code_point(), 1'b0, 1'b0);
        end
        send_beat(8'h2E, 1'b1);
    endtask

    // full rate on both sides
    task automatic test_back_to_back(input int n);
        sender_idle_en    = 1'b0;
        receiver_stall_en = 1'b0;
        test_random_text(n);
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ascii_and_controls();
        test_multibyte_mapping();
        test_broken_and_truncated();
        // sender holds off here until every owed beat has come out
        drain_results();
        test_random_text(800);
        drain_results();
        test_noise_bytes(300);
        drain_results();
        test_back_to_back(600);
        drain_results();
        // wait on to catch any beat the transcoder should not send
        repeat (10) @(posedge clk);

        $display("covered %0d utf-8 bytes in %0d texts, %0d windows-1252 beats checked",
                 beats_sent, texts_seen, beats_seen);
        $display("of which %0d substitutions, idling on both sides then back to back",
                 subst_seen);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("%0t: timeout with %0d beats still owed", $time, winansi_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
